// ----- design/rmr_pkg.sv -----
// shared constants, types and command/status structs of the resistance meter
// no dependencies
`default_nettype none
package rmr_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int VAL_W       = 42;
  localparam int NUM_W       = 46;
  localparam int DIV_W       = 15;
  localparam int DIV_STEPS   = NUM_W;
  localparam int DCNT_W      = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 42;

  localparam logic [VAL_W-1:0] OPEN_VALUE  = 42'd100000000000;
  localparam logic [VAL_W-1:0] SHORT_VALUE = 42'd1;

  localparam logic [26:0]      RST_SERIES    = 27'd10000000;
  localparam logic [CNT_W-1:0] RST_COUNT     = CNT_W'(16);
  localparam logic [14:0]      RST_SUPPLY    = 15'd26400;
  localparam logic [14:0]      RST_MARGIN    = 15'd8;
  localparam logic [VAL_W-1:0] RST_COND_LIM  = 42'd1000000;
  localparam logic [VAL_W-1:0] RST_INSUL_LIM = 42'd10000000000;

  localparam logic [CFG_IDX_W-1:0] REG_SERIES    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUPPLY    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN    = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COND_LIM  = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INSUL_LIM = 8'd5;

  localparam logic [1:0] CLASS_CONDUCTOR = 2'd0;
  localparam logic [1:0] CLASS_SEMI      = 2'd1;
  localparam logic [1:0] CLASS_INSULATOR = 2'd2;

  typedef struct packed {
    logic load;
    logic chk;
    logic div_step;
    logic fin;
    logic ins_rd;
    logic ins_shift;
    logic ins_put;
    logic qa;
    logic qb;
    logic qc;
    logic qd;
    logic scan_rd;
    logic scan_chk;
    logic med_rd;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic normal;
    logic div_done;
    logic j_zero;
    logic greater;
    logic batch_full;
    logic scan_last;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

// ----- design/rmr_if.sv -----
// valid/ready channel interfaces: input codes, results, register writes
// depends on rmr_pkg
`default_nettype none
interface rmr_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] adc_code;
  modport source (output valid, output adc_code, input ready);
  modport sink   (input valid, input adc_code, output ready);
endinterface

interface rmr_out_if;
  logic                          valid;
  logic                          ready;
  logic [rmr_pkg::VAL_W-1:0]     resistance_tenths;
  logic [1:0]                    conductivity_class;
  logic [rmr_pkg::CNT_W-1:0]     inlier_count;
  modport source (output valid, output resistance_tenths, output conductivity_class,
                  output inlier_count, input ready);
  modport sink   (input valid, input resistance_tenths, input conductivity_class,
                  input inlier_count, output ready);
endinterface

interface rmr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rmr_pkg::CFG_IDX_W-1:0]   index;
  logic [rmr_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- design/rmr_datapath.sv -----
// datapath: registers, code conversion, serial divider, sample memory,
// quartile limits, inlier scan and result register; depends on rmr_pkg
`default_nettype none
module rmr_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rmr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [rmr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic signed [15:0]             adc_code_i,
  input  wire logic                           out_ready_i,
  input  wire rmr_pkg::cmd_t                  cmd_i,
  output rmr_pkg::sts_t                       sts_o,
  output logic                                out_valid_o,
  output logic [rmr_pkg::VAL_W-1:0]           res_o,
  output logic [1:0]                          class_o,
  output logic [rmr_pkg::CNT_W-1:0]           kept_o
);

  localparam int VW = rmr_pkg::VAL_W;
  localparam int NW = rmr_pkg::NUM_W;
  localparam int CW = rmr_pkg::CNT_W;
  localparam int AW = rmr_pkg::ADDR_W;
  localparam int DW = rmr_pkg::DIV_W;
  localparam int LW = VW + 3;

  // configuration
  logic [26:0]   series_q;
  logic [CW-1:0] count_q;
  logic [14:0]   supply_q, margin_q;
  logic [VW-1:0] cond_lim_q, insul_lim_q;
  logic [CW-1:0] count_wr;

  always_comb begin
    count_wr = cfg_data_i[CW-1:0];
    if (count_wr == '0) count_wr = CW'(1);
    else if (count_wr > CW'(rmr_pkg::MAX_SAMPLES)) count_wr = CW'(rmr_pkg::MAX_SAMPLES);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      series_q    <= rmr_pkg::RST_SERIES;
      count_q     <= rmr_pkg::RST_COUNT;
      supply_q    <= rmr_pkg::RST_SUPPLY;
      margin_q    <= rmr_pkg::RST_MARGIN;
      cond_lim_q  <= rmr_pkg::RST_COND_LIM;
      insul_lim_q <= rmr_pkg::RST_INSUL_LIM;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rmr_pkg::REG_SERIES:    series_q    <= cfg_data_i[26:0];
        rmr_pkg::REG_COUNT:     count_q     <= count_wr;
        rmr_pkg::REG_SUPPLY:    supply_q    <= cfg_data_i[14:0];
        rmr_pkg::REG_MARGIN:    margin_q    <= cfg_data_i[14:0];
        rmr_pkg::REG_COND_LIM:  cond_lim_q  <= cfg_data_i[VW-1:0];
        rmr_pkg::REG_INSUL_LIM: insul_lim_q <= cfg_data_i[VW-1:0];
        default: ;
      endcase
    end
  end

  // conversion of one code
  logic signed [15:0] code_q;
  logic signed [16:0] code17, diff17, margin17;
  logic               is_open, is_short;
  logic [30:0]        series_x10;
  logic [NW-1:0]      num;

  assign code17     = {code_q[15], code_q};
  assign diff17     = $signed({2'b00, supply_q}) - code17;
  assign margin17   = $signed({2'b00, margin_q});
  assign is_open    = (diff17 <= 17'sd0) || (diff17 < margin17);
  assign is_short   = (code17 <= 17'sd0) || (code17 < margin17);
  assign series_x10 = {1'b0, series_q, 3'b000} + {3'b000, series_q, 1'b0};
  assign num        = NW'(series_x10) * NW'(code_q[14:0]);

  // restoring divider, one quotient bit a cycle
  logic [NW-1:0]                  quo_q;
  logic [DW-1:0]                  rem_q, dvs_q;
  logic [rmr_pkg::DCNT_W-1:0]     dcnt_q;
  logic [DW:0]                    trial;
  logic                           fits;
  logic [VW-1:0]                  key_q;

  assign trial = {rem_q, quo_q[NW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) code_q <= adc_code_i;
    if (cmd_i.chk) begin
      quo_q  <= num;
      rem_q  <= '0;
      dvs_q  <= diff17[DW-1:0];
      dcnt_q <= '0;
      key_q  <= is_open ? rmr_pkg::OPEN_VALUE : rmr_pkg::SHORT_VALUE;
    end
    if (cmd_i.div_step) begin
      rem_q  <= fits ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
      quo_q  <= {quo_q[NW-2:0], fits};
      dcnt_q <= dcnt_q + 1'b1;
    end
    if (cmd_i.fin) key_q <= (quo_q[NW-1:VW] != '0) ? '1 : quo_q[VW-1:0];
  end

  // sample memory, kept sorted by insertion
  logic [VW-1:0] mem_q [rmr_pkg::MAX_SAMPLES];
  logic [VW-1:0] rd_q;
  logic [AW-1:0] raddr, waddr;
  logic [VW-1:0] wdata;
  logic          re, we;
  logic [CW-1:0] fill_q, j_q, i_q, kept_q;
  logic [AW-1:0] first_q;
  logic [CW+1:0] n_x3;
  logic [CW-1:0] med_idx;

  assign n_x3    = {2'b00, count_q} + {1'b0, count_q, 1'b0};
  assign med_idx = {1'b0, first_q} + (kept_q >> 1);

  always_comb begin
    raddr = '0;
    priority if (cmd_i.ins_rd) raddr = AW'(j_q - 1'b1);
    else if (cmd_i.qa)         raddr = AW'(count_q >> 2);
    else if (cmd_i.qb)         raddr = AW'(n_x3 >> 2);
    else if (cmd_i.scan_rd)    raddr = i_q[AW-1:0];
    else if (cmd_i.med_rd)     raddr = med_idx[AW-1:0];
    else                       raddr = '0;
  end

  assign re    = cmd_i.ins_rd | cmd_i.qa | cmd_i.qb | cmd_i.scan_rd | cmd_i.med_rd;
  assign we    = cmd_i.ins_shift | cmd_i.ins_put;
  assign waddr = j_q[AW-1:0];
  assign wdata = cmd_i.ins_shift ? rd_q : key_q;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rd_q <= mem_q[raddr];
  end

  // quartile limits and inlier scan
  logic [VW-1:0]        q1_q, q3_q, iqr_q;
  logic signed [LW-1:0] lo_q, hi_q, v;
  logic                 inlier;

  assign v      = $signed({3'b000, rd_q});
  assign inlier = (v >= lo_q) && (v <= hi_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.qb) q1_q <= rd_q;
    if (cmd_i.qc) begin
      q3_q  <= rd_q;
      iqr_q <= rd_q - q1_q;
    end
    if (cmd_i.qd) begin
      lo_q <= $signed({3'b000, q1_q}) - $signed({2'b00, iqr_q, 1'b0});
      hi_q <= $signed({3'b000, q3_q}) + $signed({2'b00, iqr_q, 1'b0});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      j_q     <= '0;
      i_q     <= '0;
      kept_q  <= '0;
      first_q <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == rmr_pkg::REG_COUNT) fill_q <= '0;
      else if (cmd_i.emit) fill_q <= '0;
      else if (cmd_i.ins_put) fill_q <= fill_q + 1'b1;
      if (cmd_i.load) j_q <= fill_q;
      else if (cmd_i.ins_shift) j_q <= j_q - 1'b1;
      if (cmd_i.qd) begin
        i_q     <= '0;
        kept_q  <= '0;
        first_q <= '0;
      end else if (cmd_i.scan_chk) begin
        i_q <= i_q + 1'b1;
        if (inlier) begin
          if (kept_q == '0) first_q <= i_q[AW-1:0];
          kept_q <= kept_q + 1'b1;
        end
      end
    end
  end

  // result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.emit) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_o  <= rd_q;
      kept_o <= kept_q;
      priority if (rd_q < cond_lim_q) class_o <= rmr_pkg::CLASS_CONDUCTOR;
      else if (rd_q > insul_lim_q)    class_o <= rmr_pkg::CLASS_INSULATOR;
      else                            class_o <= rmr_pkg::CLASS_SEMI;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sts_o.normal      = !is_open && !is_short;
  assign sts_o.div_done    = dcnt_q == rmr_pkg::DCNT_W'(rmr_pkg::DIV_STEPS - 1);
  assign sts_o.j_zero      = j_q == '0;
  assign sts_o.greater     = rd_q > key_q;
  assign sts_o.batch_full  = {1'b0, fill_q} + 1'b1 >= {1'b0, count_q};
  assign sts_o.scan_last   = {1'b0, i_q} + 1'b1 == {1'b0, count_q};
  assign sts_o.out_busy    = out_valid_q && !out_ready_i;

  a_kept_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> kept_q != '0 && kept_q <= count_q)
    else $error("inlier count exceeds batch size");
  a_j_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins_rd |-> j_q != '0 && j_q <= fill_q)
    else $error("insertion position beyond fill");
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> fill_q == '0 && out_valid_q)
    else $error("batch not restarted after result");

endmodule
`default_nettype wire

// ----- design/rmr_ctrl.sv -----
// sequencer for conversion, sorted insertion, quartile scan and result
// depends on rmr_pkg
`default_nettype none
module rmr_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire rmr_pkg::sts_t sts_i,
  output rmr_pkg::cmd_t      cmd_o
);

  typedef enum logic [13:0] {
    IDLE     = 14'b00000000000001,
    CHK      = 14'b00000000000010,
    DIV      = 14'b00000000000100,
    FIN      = 14'b00000000001000,
    INS_RD   = 14'b00000000010000,
    INS_CMP  = 14'b00000000100000,
    QA       = 14'b00000001000000,
    QB       = 14'b00000010000000,
    QC       = 14'b00000100000000,
    QD       = 14'b00001000000000,
    SCAN_RD  = 14'b00010000000000,
    SCAN_CHK = 14'b00100000000000,
    MED_RD   = 14'b01000000000000,
    EMIT     = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      IDLE: if (in_valid_i) begin
        cmd_o.load = 1'b1;
        state_d    = CHK;
      end
      CHK: begin
        cmd_o.chk = 1'b1;
        state_d   = sts_i.normal ? DIV : INS_RD;
      end
      DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = FIN;
      end
      FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = INS_RD;
      end
      INS_RD: begin
        if (sts_i.j_zero) begin
          cmd_o.ins_put = 1'b1;
          state_d       = sts_i.batch_full ? QA : IDLE;
        end else begin
          cmd_o.ins_rd = 1'b1;
          state_d      = INS_CMP;
        end
      end
      INS_CMP: begin
        if (sts_i.greater) begin
          cmd_o.ins_shift = 1'b1;
          state_d         = INS_RD;
        end else begin
          cmd_o.ins_put = 1'b1;
          state_d       = sts_i.batch_full ? QA : IDLE;
        end
      end
      QA: begin
        cmd_o.qa = 1'b1;
        state_d  = QB;
      end
      QB: begin
        cmd_o.qb = 1'b1;
        state_d  = QC;
      end
      QC: begin
        cmd_o.qc = 1'b1;
        state_d  = QD;
      end
      QD: begin
        cmd_o.qd = 1'b1;
        state_d  = SCAN_RD;
      end
      SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = SCAN_CHK;
      end
      SCAN_CHK: begin
        cmd_o.scan_chk = 1'b1;
        state_d        = sts_i.scan_last ? MED_RD : SCAN_RD;
      end
      MED_RD: begin
        cmd_o.med_rd = 1'b1;
        state_d      = EMIT;
      end
      EMIT: if (!sts_i.out_busy) begin
        cmd_o.emit = 1'b1;
        state_d    = IDLE;
      end
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= IDLE;
    else         state_q <= state_d;
  end

  assign in_ready_o = state_q == IDLE;

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == CHK)
    else $error("load not followed by range check");
  a_emit_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> !cmd_o.emit)
    else $error("result issued twice");
  a_scan_after_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.qd |=> cmd_o.scan_rd)
    else $error("scan did not start after limits");

endmodule
`default_nettype wire

// ----- design/robust_median_resistance_meter_unit.sv -----
// top level of the resistance meter: channels, sequencer and datapath
// depends on rmr_pkg, rmr_if, rmr_ctrl, rmr_datapath
`default_nettype none
// Converts signed divider codes to resistance in tenths of an ohm and, once
// sample_count codes are in, reports the median of the values that lie within
// two interquartile ranges of the quartiles, with a class and the inlier count.
// A code is taken only while the block is idle. A code near a rail skips the
// divider; any other code goes through the 46-step serial divider.
// Each code is then placed into the sorted sample memory by insertion, moving
// past one entry at a time over one memory port. The last code of a batch
// then runs the quartile limits, the inlier scan over all sample_count entries
// and the median read and result. The result sits in an output register; a new
// code is taken while it waits. Register writes are always accepted; writing
// sample_count drops the partial batch.
module robust_median_resistance_meter_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rmr_in_if.sink    in_i,
  rmr_out_if.source out_o,
  rmr_cfg_if.sink   cfg_i
);

  rmr_pkg::cmd_t cmd;
  rmr_pkg::sts_t sts;
  logic          cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  rmr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rmr_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .adc_code_i  (in_i.adc_code),
    .out_ready_i (out_o.ready),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .res_o       (out_o.resistance_tenths),
    .class_o     (out_o.conductivity_class),
    .kept_o      (out_o.inlier_count)
  );

endmodule
`default_nettype wire
